// ===== rtl/core/grid_bucket_hash_table_assert.svh =====
// ----------------------------------------------------------------------------
// grid bucket hash table assertion macros
// shared property forms for the hash table checks
// ----------------------------------------------------------------------------
`ifndef GRID_BUCKET_HASH_TABLE_ASSERT_SVH
`define GRID_BUCKET_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define GBHT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GBHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/gbht_pkg.sv =====
// ----------------------------------------------------------------------------
// gbht_pkg
// types, sizes and codes of the grid bucket hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbht_pkg;

  localparam int MAX_BUCKETS    = 1024;
  localparam int SLOTS          = 4;
  localparam int OVERFLOW_DEPTH = 8;
  localparam int HANDLE_BITS    = 32;
  localparam int COORD_BITS     = 32;
  localparam int CFG_BITS       = 11;
  localparam int BUCKET_BITS    = 10;
  localparam int SLOT_BITS      = 2;
  localparam int OVF_BITS       = 3;
  localparam int SC_BITS        = 3;
  localparam int OC_BITS        = 4;
  localparam int OCC_BITS       = 4;
  localparam int STATUS_BITS    = 4;

  localparam logic [STATUS_BITS-1:0] ST_INS_SLOT    = 4'd0;
  localparam logic [STATUS_BITS-1:0] ST_INS_OVF     = 4'd1;
  localparam logic [STATUS_BITS-1:0] ST_RM_LAST     = 4'd2;
  localparam logic [STATUS_BITS-1:0] ST_RM_MOVED    = 4'd3;
  localparam logic [STATUS_BITS-1:0] ST_RM_FROM_OVF = 4'd4;
  localparam logic [STATUS_BITS-1:0] ST_RM_OVF      = 4'd5;
  localparam logic [STATUS_BITS-1:0] ST_ZERO        = 4'd6;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND   = 4'd7;
  localparam logic [STATUS_BITS-1:0] ST_OVF_FULL    = 4'd8;
  localparam logic [STATUS_BITS-1:0] ST_BAD_GEOM    = 4'd9;

  localparam logic ACT_INSERT = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEOM, S_MOD, S_MUL, S_ADD, S_CNT,
    S_SRD, S_SCMP, S_FILL_OVF, S_FILL_SLOT, S_ORD, S_OCMP, S_SHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] dividend;
    logic [CFG_BITS-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic                done;
    logic [CFG_BITS-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== rtl/core/gbht_ram.sv =====
// ----------------------------------------------------------------------------
// gbht_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbht_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/gbht_mod_unit.sv =====
// ----------------------------------------------------------------------------
// gbht_mod_unit
// restoring remainder of a coordinate by a grid size, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbht_mod_unit (
  input  logic              clk,
  input  logic              rst,
  input  gbht_pkg::mod_req_t req,
  output gbht_pkg::mod_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(gbht_pkg::COORD_BITS);

  logic                            busy;
  logic [CNT_BITS-1:0]             cnt;
  logic [gbht_pkg::COORD_BITS-1:0] dvd;
  logic [gbht_pkg::CFG_BITS-1:0]   divisor;
  logic [gbht_pkg::CFG_BITS-1:0]   rem;
  logic [gbht_pkg::CFG_BITS:0]     trial;
  logic                            done;

  assign trial = {rem, dvd[gbht_pkg::COORD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        dvd     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= gbht_pkg::CFG_BITS'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[gbht_pkg::CFG_BITS-1:0];
        end
        dvd <= {dvd[gbht_pkg::COORD_BITS-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(gbht_pkg::COORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ===== rtl/core/grid_bucket_hash_table.sv =====
// ----------------------------------------------------------------------------
// grid bucket hash table
// grid spatial hash with per-bucket slots and a bounded overflow stack
// ----------------------------------------------------------------------------
// channel   dir  signals                     content
// s         in   s_tvalid s_tready s_tdata   request: x, y, handle; tuser action
// m         out  m_tvalid m_tready m_tdata   result: status, bucket, occupancy
// cfg       in   cfg_we cfg_index cfg_data   grid width (0), grid height (1)
//
// one request at a time; a remove can take longer than an insert, since it
// searches. the time is set by the two bit-serial modulo units and the single
// read port of each store, from which a search reads one entry at a time.
// after reset a clearing pass zeroes all 1024 bucket counts.
// a waiting result is held in the output register while the next request
// is taken; the block stalls at completion only if that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "grid_bucket_hash_table_assert.svh"

module grid_bucket_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pos_x, pos_y, handle
  input  logic [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status, bucket_index, occupancy, zero fill
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int SADDR = gbht_pkg::BUCKET_BITS + gbht_pkg::SLOT_BITS;
  localparam int OADDR = gbht_pkg::BUCKET_BITS + gbht_pkg::OVF_BITS;
  localparam int CBITS = gbht_pkg::SC_BITS + gbht_pkg::OC_BITS;
  localparam int HB    = gbht_pkg::HANDLE_BITS;
  localparam int WB    = gbht_pkg::CFG_BITS;

  gbht_pkg::state_t state, state_next;

  logic [WB-1:0] grid_width, grid_height;

  logic                               act;
  logic [gbht_pkg::COORD_BITS-1:0]    pos_x, pos_y;
  logic [HB-1:0]                      handle;
  logic [2*WB-1:0]                    prod;
  logic [gbht_pkg::BUCKET_BITS-1:0]   bucket, clr_addr;
  logic [gbht_pkg::SC_BITS-1:0]       sc, idx;
  logic [gbht_pkg::OC_BITS-1:0]       oc, k;
  logic [gbht_pkg::SLOT_BITS-1:0]     hit;
  logic [gbht_pkg::STATUS_BITS-1:0]   status;

  logic [2*WB-1:0]                    geo_prod;
  logic                               geo_bad;
  logic [WB-1:0]                      bucket_sum;

  gbht_pkg::mod_req_t mx_req, my_req;
  gbht_pkg::mod_rsp_t mx_rsp, my_rsp;

  logic             s_we, o_we, c_we;
  logic [SADDR-1:0] s_waddr, s_raddr;
  logic [OADDR-1:0] o_waddr, o_raddr;
  logic [HB-1:0]    s_wdata, o_wdata, s_rdata, o_rdata;
  logic [gbht_pkg::BUCKET_BITS-1:0] c_waddr, c_raddr;
  logic [CBITS-1:0] c_wdata, c_rdata;

  logic [gbht_pkg::SC_BITS-1:0] sc_new;
  logic [gbht_pkg::OC_BITS-1:0] oc_new;
  logic [gbht_pkg::STATUS_BITS-1:0] status_new;
  logic load_status;

  logic slot_hit, ovf_hit;

  assign geo_prod   = grid_width * grid_height;
  assign geo_bad    = (grid_width == '0) || (grid_height == '0) ||
                      (geo_prod > (2*WB)'(gbht_pkg::MAX_BUCKETS));
  assign bucket_sum = prod[WB-1:0] + mx_rsp.rem;
  assign slot_hit   = (s_rdata == handle);
  assign ovf_hit    = (o_rdata == handle);
  assign s_tready   = (state == gbht_pkg::S_IDLE);

  assign mx_req.start    = (state == gbht_pkg::S_GEOM) && !geo_bad;
  assign mx_req.dividend = pos_x;
  assign mx_req.divisor  = grid_width;
  assign my_req.start    = mx_req.start;
  assign my_req.dividend = pos_y;
  assign my_req.divisor  = grid_height;

  gbht_mod_unit u_mod_x (.clk(clk), .rst(rst), .req(mx_req), .rsp(mx_rsp));
  gbht_mod_unit u_mod_y (.clk(clk), .rst(rst), .req(my_req), .rsp(my_rsp));

  gbht_ram #(.ADDR_BITS(SADDR), .DATA_BITS(HB)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  gbht_ram #(.ADDR_BITS(OADDR), .DATA_BITS(HB)) u_ovf_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  gbht_ram #(.ADDR_BITS(gbht_pkg::BUCKET_BITS), .DATA_BITS(CBITS)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= WB'(32);
      grid_height <= WB'(32);
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_we        = 1'b0;
    o_we        = 1'b0;
    c_we        = 1'b0;
    s_waddr     = {bucket, sc[gbht_pkg::SLOT_BITS-1:0]};
    s_wdata     = handle;
    o_waddr     = {bucket, oc[gbht_pkg::OVF_BITS-1:0]};
    o_wdata     = handle;
    s_raddr     = {bucket, idx[gbht_pkg::SLOT_BITS-1:0]};
    o_raddr     = {bucket, k[gbht_pkg::OVF_BITS-1:0]};
    c_waddr     = bucket;
    c_raddr     = (state == gbht_pkg::S_ADD) ? bucket_sum[gbht_pkg::BUCKET_BITS-1:0]
                                             : bucket;
    sc_new      = sc;
    oc_new      = oc;
    c_wdata     = {oc_new, sc_new};
    status_new  = status;
    load_status = 1'b0;
    unique case (state)
      gbht_pkg::S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_addr;
        c_wdata = '0;
        if (clr_addr == '1) begin
          state_next = gbht_pkg::S_IDLE;
        end
      end
      gbht_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = gbht_pkg::S_GEOM;
        end
      end
      gbht_pkg::S_GEOM: begin
        sc_new = '0;
        oc_new = '0;
        if (geo_bad) begin
          load_status = 1'b1;
          status_new  = gbht_pkg::ST_BAD_GEOM;
          state_next  = gbht_pkg::S_DONE;
        end else begin
          state_next = gbht_pkg::S_MOD;
        end
      end
      gbht_pkg::S_MOD: begin
        if (mx_rsp.done) begin
          state_next = gbht_pkg::S_MUL;
        end
      end
      gbht_pkg::S_MUL: state_next = gbht_pkg::S_ADD;
      gbht_pkg::S_ADD: state_next = gbht_pkg::S_CNT;
      gbht_pkg::S_CNT: begin
        sc_new      = c_rdata[gbht_pkg::SC_BITS-1:0];
        oc_new      = c_rdata[CBITS-1:gbht_pkg::SC_BITS];
        load_status = 1'b1;
        state_next  = gbht_pkg::S_DONE;
        if (handle == '0) begin
          status_new = gbht_pkg::ST_ZERO;
        end else if (act == gbht_pkg::ACT_INSERT) begin
          if (sc_new < gbht_pkg::SC_BITS'(gbht_pkg::SLOTS)) begin
            s_we       = 1'b1;
            s_waddr    = {bucket, sc_new[gbht_pkg::SLOT_BITS-1:0]};
            sc_new     = sc_new + 1'b1;
            c_we       = 1'b1;
            status_new = gbht_pkg::ST_INS_SLOT;
          end else if (oc_new < gbht_pkg::OC_BITS'(gbht_pkg::OVERFLOW_DEPTH)) begin
            o_we       = 1'b1;
            o_waddr    = {bucket, oc_new[gbht_pkg::OVF_BITS-1:0]};
            oc_new     = oc_new + 1'b1;
            c_we       = 1'b1;
            status_new = gbht_pkg::ST_INS_OVF;
          end else begin
            status_new = gbht_pkg::ST_OVF_FULL;
          end
          c_wdata = {oc_new, sc_new};
        end else if (sc_new != '0) begin
          load_status = 1'b0;
          state_next  = gbht_pkg::S_SRD;
        end else if (oc_new != '0) begin
          load_status = 1'b0;
          state_next  = gbht_pkg::S_ORD;
        end else begin
          status_new = gbht_pkg::ST_NOT_FOUND;
        end
      end
      gbht_pkg::S_SRD: state_next = gbht_pkg::S_SCMP;
      gbht_pkg::S_SCMP: begin
        if (slot_hit) begin
          if (oc != '0) begin
            o_raddr    = {bucket, 3'(oc - 1'b1)};
            state_next = gbht_pkg::S_FILL_OVF;
          end else if (idx == sc - 1'b1) begin
            sc_new      = sc - 1'b1;
            c_we        = 1'b1;
            c_wdata     = {oc_new, sc_new};
            load_status = 1'b1;
            status_new  = gbht_pkg::ST_RM_LAST;
            state_next  = gbht_pkg::S_DONE;
          end else begin
            s_raddr    = {bucket, 2'(sc - 1'b1)};
            state_next = gbht_pkg::S_FILL_SLOT;
          end
        end else if (idx + 1'b1 < sc) begin
          state_next = gbht_pkg::S_SRD;
        end else if (oc != '0) begin
          state_next = gbht_pkg::S_ORD;
        end else begin
          load_status = 1'b1;
          status_new  = gbht_pkg::ST_NOT_FOUND;
          state_next  = gbht_pkg::S_DONE;
        end
      end
      gbht_pkg::S_FILL_OVF: begin
        s_we        = 1'b1;
        s_waddr     = {bucket, hit};
        s_wdata     = o_rdata;
        oc_new      = oc - 1'b1;
        c_we        = 1'b1;
        c_wdata     = {oc_new, sc_new};
        load_status = 1'b1;
        status_new  = gbht_pkg::ST_RM_FROM_OVF;
        state_next  = gbht_pkg::S_DONE;
      end
      gbht_pkg::S_FILL_SLOT: begin
        s_we        = 1'b1;
        s_waddr     = {bucket, hit};
        s_wdata     = s_rdata;
        sc_new      = sc - 1'b1;
        c_we        = 1'b1;
        c_wdata     = {oc_new, sc_new};
        load_status = 1'b1;
        status_new  = gbht_pkg::ST_RM_MOVED;
        state_next  = gbht_pkg::S_DONE;
      end
      gbht_pkg::S_ORD: state_next = gbht_pkg::S_OCMP;
      gbht_pkg::S_OCMP: begin
        if (ovf_hit) begin
          if (k + 1'b1 < oc) begin
            o_raddr    = {bucket, 3'(k + 1'b1)};
            state_next = gbht_pkg::S_SHIFT;
          end else begin
            oc_new      = oc - 1'b1;
            c_we        = 1'b1;
            c_wdata     = {oc_new, sc_new};
            load_status = 1'b1;
            status_new  = gbht_pkg::ST_RM_OVF;
            state_next  = gbht_pkg::S_DONE;
          end
        end else if (k != '0) begin
          state_next = gbht_pkg::S_ORD;
        end else begin
          load_status = 1'b1;
          status_new  = gbht_pkg::ST_NOT_FOUND;
          state_next  = gbht_pkg::S_DONE;
        end
      end
      gbht_pkg::S_SHIFT: begin
        // move the next newer entry down, read the one after it
        o_we    = 1'b1;
        o_waddr = {bucket, k[gbht_pkg::OVF_BITS-1:0]};
        o_wdata = o_rdata;
        o_raddr = {bucket, 3'(k + 4'd2)};
        if (k + 4'd2 >= oc) begin
          oc_new      = oc - 1'b1;
          c_we        = 1'b1;
          c_wdata     = {oc_new, sc_new};
          load_status = 1'b1;
          status_new  = gbht_pkg::ST_RM_OVF;
          state_next  = gbht_pkg::S_DONE;
        end
      end
      gbht_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = gbht_pkg::S_IDLE;
        end
      end
      default: state_next = gbht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == gbht_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == gbht_pkg::S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sc <= sc_new;
    oc <= oc_new;
    if (load_status) begin
      status <= status_new;
    end
    case (state)
      gbht_pkg::S_IDLE: begin
        pos_x  <= s_tdata[31:0];
        pos_y  <= s_tdata[63:32];
        handle <= s_tdata[95:64];
        act    <= s_tuser[0];
      end
      gbht_pkg::S_GEOM: bucket <= '0;
      gbht_pkg::S_MUL: prod <= grid_width * my_rsp.rem;
      gbht_pkg::S_ADD: bucket <= bucket_sum[gbht_pkg::BUCKET_BITS-1:0];
      gbht_pkg::S_CNT: begin
        idx <= '0;
        k   <= oc_new - 1'b1;
      end
      gbht_pkg::S_SCMP: begin
        hit <= idx[gbht_pkg::SLOT_BITS-1:0];
        idx <= idx + 1'b1;
        k   <= oc - 1'b1;
      end
      gbht_pkg::S_OCMP: begin
        if (!ovf_hit) begin
          k <= k - 1'b1;
        end
      end
      gbht_pkg::S_SHIFT: k <= k + 1'b1;
      default: begin
      end
    endcase
    if (state == gbht_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {6'd0, 4'(sc + oc), bucket, status};
    end
  end

  `GBHT_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `GBHT_ASSERT_NOW(a_occ_bound, clk, rst, m_tvalid,
    m_tdata[17:14] <= 4'(gbht_pkg::SLOTS + gbht_pkg::OVERFLOW_DEPTH))
  `GBHT_ASSERT_NOW(a_bad_geom_zero, clk, rst,
    m_tvalid && m_tdata[3:0] == gbht_pkg::ST_BAD_GEOM,
    m_tdata[13:4] == '0 && m_tdata[17:14] == '0)

endmodule

// ===== tb/tb_grid_bucket_hash_table.sv =====
// ----------------------------------------------------------------------------
// grid bucket hash table testbench
// drives insert and remove requests across several grid geometries, predicts
// status, bucket and occupancy from a behavioral table, and checks every
// result transfer in order under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_bucket_hash_table;

  typedef struct packed {
    logic        act;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
  } req_t;

  typedef struct packed {
    logic [3:0] occ;
    logic [9:0] bucket;
    logic [3:0] status;
  } rsp_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  grid_bucket_hash_table dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [31:0] slot_tab [gbht_pkg::MAX_BUCKETS][gbht_pkg::SLOTS];
  logic [31:0] ovf_tab  [gbht_pkg::MAX_BUCKETS][gbht_pkg::OVERFLOW_DEPTH];
  int          slot_cnt [gbht_pkg::MAX_BUCKETS];
  int          ovf_cnt  [gbht_pkg::MAX_BUCKETS];
  int          gw = 32, gh = 32;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   checked = 0;
  int   status_seen [16];
  logic hold = 1'b0;
  int   gap = 0, burst = 0, stall_phase = 0;

  task automatic report(input string what, input rsp_t got, input rsp_t exp);
    errors++;
    $display("mismatch %s: got st=%0d b=%0d occ=%0d exp st=%0d b=%0d occ=%0d", what,
             got.status, got.bucket, got.occ, exp.status, exp.bucket, exp.occ);
  endtask

  function automatic rsp_t hash_apply(input req_t r);
    rsp_t o;
    int b, sc, oc, i, k;
    logic done;
    o = '0;
    done = 1'b0;
    if (gw == 0 || gh == 0 || gw * gh > gbht_pkg::MAX_BUCKETS) begin
      o.status = gbht_pkg::ST_BAD_GEOM;
      return o;
    end
    b = gw * (r.y % gh) + (r.x % gw);
    sc = slot_cnt[b];
    oc = ovf_cnt[b];
    if (r.h == 0) begin
      o.status = gbht_pkg::ST_ZERO;
    end else if (r.act == gbht_pkg::ACT_INSERT) begin
      if (sc < gbht_pkg::SLOTS) begin
        slot_tab[b][sc] = r.h; slot_cnt[b] = sc + 1; o.status = gbht_pkg::ST_INS_SLOT;
      end else if (oc < gbht_pkg::OVERFLOW_DEPTH) begin
        ovf_tab[b][oc] = r.h; ovf_cnt[b] = oc + 1; o.status = gbht_pkg::ST_INS_OVF;
      end else begin
        o.status = gbht_pkg::ST_OVF_FULL;
      end
    end else begin
      o.status = gbht_pkg::ST_NOT_FOUND;
      for (i = 0; i < sc && !done; i++) begin
        if (slot_tab[b][i] == r.h) begin
          done = 1'b1;
          if (oc > 0) begin
            slot_tab[b][i] = ovf_tab[b][oc-1]; ovf_cnt[b] = oc - 1;
            o.status = gbht_pkg::ST_RM_FROM_OVF;
          end else begin
            slot_cnt[b] = sc - 1;
            if (i == sc - 1) o.status = gbht_pkg::ST_RM_LAST;
            else begin
              slot_tab[b][i] = slot_tab[b][sc-1]; o.status = gbht_pkg::ST_RM_MOVED;
            end
          end
        end
      end
      for (i = oc; i > 0 && !done; i--) begin
        if (ovf_tab[b][i-1] == r.h) begin
          done = 1'b1;
          for (k = i - 1; k + 1 < oc; k++) ovf_tab[b][k] = ovf_tab[b][k+1];
          ovf_cnt[b] = oc - 1;
          o.status = gbht_pkg::ST_RM_OVF;
        end
      end
    end
    o.bucket = b[9:0];
    o.occ = 4'(slot_cnt[b] + ovf_cnt[b]);
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid && s_tready) expected_rsps.push_back(hash_apply(pending_reqs.pop_front()));
      if (gap > 0) begin
        gap <= gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_reqs[0].h, pending_reqs[0].y, pending_reqs[0].x};
        s_tuser <= pending_reqs[0].act;
        if (burst == 0) begin
          burst <= $urandom_range(1, 12);
          gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst <= burst - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    rsp_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[17:0];
        if (expected_rsps.size() == 0) begin
          report("unexpected", got, '0);
        end else begin
          if (got.status !== expected_rsps[0].status) report("status", got, expected_rsps[0]);
          else if (got.bucket !== expected_rsps[0].bucket) report("bucket", got, expected_rsps[0]);
          else if (got.occ !== expected_rsps[0].occ) report("occupancy", got, expected_rsps[0]);
          status_seen[expected_rsps[0].status]++;
          void'(expected_rsps.pop_front());
        end
        checked++;
      end
      stall_phase <= (stall_phase + 1) % 97;
      m_tready <= (stall_phase < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic add_req(input logic a, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] h);
    req_t r;
    r.act = a; r.x = x; r.y = y; r.h = h;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int hh);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_WIDTH; cfg_data <= 11'(w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= 11'(hh);
    @(posedge clk);
    cfg_we <= 1'b0;
    gw = w; gh = hh;
  endtask

  // mostly well-formed inserts and removes on a few hot buckets
  task automatic random_phase(input int n);
    logic [31:0] live[$];
    logic [31:0] x, y, h;
    int i, j, nb;
    nb = $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      j = $urandom_range(0, 9);
      x = (j < 8) ? 32'($urandom_range(0, nb - 1)) : $urandom();
      y = (j < 7) ? 32'($urandom_range(0, 1)) : $urandom();
      if (j == 9) begin
        add_req(1'($urandom_range(0, 1)), x, y,
                ($urandom_range(0, 1) != 0) ? 32'h0 : $urandom());
      end else if (live.size() > 0 && $urandom_range(0, 1) != 0) begin
        j = $urandom_range(0, live.size() - 1);
        add_req(1'b1, x, y, live[j]);
        live.delete(j);
      end else begin
        h = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(1, 6)) : $urandom();
        if (h == 0) h = 32'hffff_ffff;
        live.push_back(h);
        add_req(1'b0, x, y, h);
      end
    end
  endtask

  initial begin
    int p;
    for (int b = 0; b < gbht_pkg::MAX_BUCKETS; b++) begin
      slot_cnt[b] = 0;
      ovf_cnt[b] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: fill one bucket past overflow, remove in every way
    for (int i = 1; i <= 13; i++) add_req(gbht_pkg::ACT_INSERT, 32'd32, 32'd64, 32'(i));
    add_req(1'b1, 0, 0, 32'd2);
    add_req(1'b1, 0, 0, 32'd7);
    add_req(1'b1, 0, 0, 32'd99);
    add_req(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
    add_req(1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_req(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_req(1'b0, 5, 5, 32'h5555_aaaa);
    add_req(1'b0, 5, 5, 32'haaaa_5555);
    add_req(1'b1, 5, 5, 32'h5555_aaaa);
    add_req(1'b1, 5, 5, 32'haaaa_5555);
    drain();

    // hold-off with nothing expected, then continue
    hold = 1'b1;
    random_phase(20);
    repeat (50) @(posedge clk);
    hold = 1'b0;
    drain();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_geometry(1, 1);
        1: set_geometry(1024, 1);
        2: set_geometry(1, 1024);
        3: set_geometry(0, 5);
        4: set_geometry(3, 0);
        5: set_geometry(2047, 2047);
        6: set_geometry(33, 31);
        default: set_geometry($urandom_range(1, 40), $urandom_range(1, 25));
      endcase
      random_phase((p >= 3 && p <= 5) ? 30 : 200);
      drain();
    end
    set_geometry(32, 32);
    random_phase(200);
    drain();

    $display("checked %0d results over nine geometries including bad ones", checked);
    $display("statuses: ins %0d/%0d rm %0d/%0d/%0d/%0d zero %0d nf %0d full %0d geom %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7],
             status_seen[8], status_seen[9]);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
